// ===== hdl/fdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdm_pkg;

    // Frame store geometry (depth must be a power of two)
    localparam int MAX_PIXELS = 1048576;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);

    // Field widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int SUM_W   = 30;
    localparam int MEAN_W  = 10;
    localparam int TOTAL_W = 10;
    localparam int AREA_W  = 2 * SIZE_W - 1;
    localparam int PROD_W  = COORD_W + SIZE_W;
    localparam int DIV_W   = SUM_W + 1;
    localparam int STEP_W  = $clog2(MEAN_W);

    // Size limits and reset values
    localparam logic [SIZE_W-1:0] SIZE_LIMIT    = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(480);
    localparam logic [SUM_W-1:0]  SUM_LIMIT     = '1;
    localparam logic [MEAN_W-1:0] MEAN_LIMIT    = '1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    // Controller to datapath commands
    typedef struct packed {
        logic load_pixel;   // capture input pixel, start store read
        logic update;       // form differences, update sum, write store
        logic div_start;    // set up the mean division
        logic div_step;     // one quotient bit
        logic load_out;     // fill output register, advance counters
    } fdm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;         // pixel in work is the last of its frame
        logic div_last;     // current division step is the final one
        logic out_free;     // output register can take a result this cycle
    } fdm_status_t;

    // Size register to usable size 1..1024
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] res;
        if (v == '0)
            res = SIZE_W'(1);
        else if (v > SIZE_LIMIT)
            res = SIZE_LIMIT;
        else
            res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/frame_difference_motion_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ---------------------------------------------
// in        input      in_valid / in_stall     blue, green, red
// out       output     out_valid / out_stall   column, row, blue/green/red_difference,
//                                              have_previous, frame_end, mean_difference
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A pixel passes through accept with frame store read, difference with store write,
// and output load. The last pixel of a frame also passes through a divider setup
// and the shift-subtract divider that forms the mean, one quotient bit per cycle.
// Reset clears counters, sum and the previous-frame flag; the frame store is not cleared.
// A result waits in the output register while the next pixel is taken in; a pixel
// finishing while out_stall holds the register waits in its final state.

module frame_difference_motion_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fdm_pkg::CH_W-1:0]          blue,
    input  wire logic [fdm_pkg::CH_W-1:0]          green,
    input  wire logic [fdm_pkg::CH_W-1:0]          red,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [fdm_pkg::COORD_W-1:0]       column,
    output logic      [fdm_pkg::COORD_W-1:0]       row,
    output logic      [fdm_pkg::CH_W-1:0]          blue_difference,
    output logic      [fdm_pkg::CH_W-1:0]          green_difference,
    output logic      [fdm_pkg::CH_W-1:0]          red_difference,
    output logic                                   have_previous,
    output logic                                   frame_end,
    output logic      [fdm_pkg::MEAN_W-1:0]        mean_difference,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fdm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fdm_pkg::SIZE_W-1:0]        cfg_data
);

    fdm_pkg::fdm_cmd_t    cmd;
    fdm_pkg::fdm_status_t status;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    fdm_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    fdm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .blue             (blue),
        .green            (green),
        .red              (red),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .column           (column),
        .row              (row),
        .blue_difference  (blue_difference),
        .green_difference (green_difference),
        .red_difference   (red_difference),
        .have_previous    (have_previous),
        .frame_end        (frame_end),
        .mean_difference  (mean_difference)
    );

    // One pixel in work at a time
    ap_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("pixel accepted while another is in work");

    // Mean is zero away from frame end
    ap_mean_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> (mean_difference == '0))
        else $error("mean reported outside frame end");

    // No differences before a previous frame exists
    ap_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !have_previous) |->
            (blue_difference == '0 && green_difference == '0 && red_difference == '0))
        else $error("difference reported without a previous frame");

    // Output register loaded only when free
    ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

// ===== hdl/fdm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fdm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdm_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fdm_pkg::fdm_cmd_t                 cmd,
    output fdm_pkg::fdm_status_t                   status,
    input  wire logic [fdm_pkg::CH_W-1:0]          blue,
    input  wire logic [fdm_pkg::CH_W-1:0]          green,
    input  wire logic [fdm_pkg::CH_W-1:0]          red,
    input  wire logic                              cfg_valid,
    input  wire logic [fdm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fdm_pkg::SIZE_W-1:0]        cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [fdm_pkg::COORD_W-1:0]       column,
    output logic      [fdm_pkg::COORD_W-1:0]       row,
    output logic      [fdm_pkg::CH_W-1:0]          blue_difference,
    output logic      [fdm_pkg::CH_W-1:0]          green_difference,
    output logic      [fdm_pkg::CH_W-1:0]          red_difference,
    output logic                                   have_previous,
    output logic                                   frame_end,
    output logic      [fdm_pkg::MEAN_W-1:0]        mean_difference
);

    // Configuration and frame control state
    logic [fdm_pkg::SIZE_W-1:0]  width_reg;
    logic [fdm_pkg::SIZE_W-1:0]  height_reg;
    logic [fdm_pkg::COORD_W-1:0] col_reg, col_next;
    logic [fdm_pkg::COORD_W-1:0] row_reg, row_next;
    logic [fdm_pkg::SUM_W-1:0]   sum_reg;
    logic                        prev_valid_reg;
    logic                        out_valid_reg;

    // Pixel in work
    logic [fdm_pkg::CH_W-1:0]    blue_reg, green_reg, red_reg;
    logic [fdm_pkg::AREA_W-1:0]  area_reg;
    logic [fdm_pkg::CH_W-1:0]    db_reg, dg_reg, dr_reg;
    logic                        last_reg;
    logic                        last_col_reg;

    // Divider
    logic [fdm_pkg::DIV_W-1:0]   rem_reg;
    logic [fdm_pkg::DIV_W-1:0]   dsr_reg;
    logic [fdm_pkg::MEAN_W-1:0]  quot_reg;
    logic [fdm_pkg::STEP_W-1:0]  step_reg;
    logic                        sat_reg;

    // Output register
    logic [fdm_pkg::COORD_W-1:0] column_reg, row_reg_out;
    logic [fdm_pkg::CH_W-1:0]    bd_out_reg, gd_out_reg, rd_out_reg;
    logic                        have_prev_out_reg;
    logic                        frame_end_reg;
    logic [fdm_pkg::MEAN_W-1:0]  mean_reg;

    logic [fdm_pkg::SIZE_W-1:0]  w_eff, h_eff;
    logic                        last_col, last_pix;
    logic [fdm_pkg::PROD_W-1:0]  addr_full;
    logic [fdm_pkg::ADDR_W-1:0]  addr;
    logic [fdm_pkg::PIX_W-1:0]   prev_pix;
    logic [fdm_pkg::CH_W-1:0]    db, dg, dr;
    logic [fdm_pkg::TOTAL_W-1:0] diff_total;
    logic [fdm_pkg::DIV_W-1:0]   sum_add;
    logic [fdm_pkg::SUM_W-1:0]   sum_next;
    logic [fdm_pkg::DIV_W-1:0]   area_top;
    logic                        out_taken;

    function automatic logic [fdm_pkg::CH_W-1:0] abs_diff(
        input logic [fdm_pkg::CH_W-1:0] a,
        input logic [fdm_pkg::CH_W-1:0] b
    );
        logic [fdm_pkg::CH_W-1:0] res;
        if (a > b)
            res = a - b;
        else
            res = b - a;
        return res;
    endfunction

    // Frame geometry and store address
    always_comb
    begin
        w_eff     = fdm_pkg::clamp_size(width_reg);
        h_eff     = fdm_pkg::clamp_size(height_reg);
        last_col  = {1'b0, col_reg} >= (w_eff - fdm_pkg::SIZE_W'(1));
        last_pix  = last_col && ({1'b0, row_reg} >= (h_eff - fdm_pkg::SIZE_W'(1)));
        addr_full = fdm_pkg::PROD_W'(row_reg) * fdm_pkg::PROD_W'(w_eff)
                  + fdm_pkg::PROD_W'(col_reg);
        addr      = addr_full[fdm_pkg::ADDR_W-1:0];
    end

    // Frame store
    fdm_ram #(
        .WIDTH (fdm_pkg::PIX_W),
        .DEPTH (fdm_pkg::MAX_PIXELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (addr),
        .wr_data ({red_reg, green_reg, blue_reg}),
        .rd_en   (cmd.load_pixel),
        .rd_addr (addr),
        .rd_data (prev_pix)
    );

    // Channel differences and saturating frame sum
    always_comb
    begin
        if (prev_valid_reg)
        begin
            db = abs_diff(blue_reg,  prev_pix[fdm_pkg::CH_W-1:0]);
            dg = abs_diff(green_reg, prev_pix[2*fdm_pkg::CH_W-1:fdm_pkg::CH_W]);
            dr = abs_diff(red_reg,   prev_pix[3*fdm_pkg::CH_W-1:2*fdm_pkg::CH_W]);
        end
        else
        begin
            db = '0;
            dg = '0;
            dr = '0;
        end
        diff_total = fdm_pkg::TOTAL_W'(db) + fdm_pkg::TOTAL_W'(dg)
                   + fdm_pkg::TOTAL_W'(dr);
        sum_add    = {1'b0, sum_reg} + fdm_pkg::DIV_W'(diff_total);
        if (sum_add > fdm_pkg::DIV_W'(fdm_pkg::SUM_LIMIT))
            sum_next = fdm_pkg::SUM_LIMIT;
        else
            sum_next = sum_add[fdm_pkg::SUM_W-1:0];
        area_top   = fdm_pkg::DIV_W'(area_reg) << fdm_pkg::MEAN_W;
    end

    // Counter advance after a pixel
    always_comb
    begin
        col_next = col_reg + fdm_pkg::COORD_W'(1);
        row_next = row_reg;
        if (last_reg)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (last_col_reg)
        begin
            col_next = '0;
            row_next = row_reg + fdm_pkg::COORD_W'(1);
        end
    end

    assign out_taken = out_valid_reg && !out_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= fdm_pkg::WIDTH_RESET;
            height_reg     <= fdm_pkg::HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            sum_reg        <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == fdm_pkg::CFG_FRAME_WIDTH)
                width_reg <= cfg_data;
            if (cfg_valid && cfg_index == fdm_pkg::CFG_FRAME_HEIGHT)
                height_reg <= cfg_data;
            if (cmd.update)
                sum_reg <= sum_next;
            if (cmd.load_out)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (last_reg)
                begin
                    sum_reg        <= '0;
                    prev_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            blue_reg  <= blue;
            green_reg <= green;
            red_reg   <= red;
            area_reg  <= fdm_pkg::AREA_W'(w_eff) * fdm_pkg::AREA_W'(h_eff);
        end
        if (cmd.update)
        begin
            db_reg       <= db;
            dg_reg       <= dg;
            dr_reg       <= dr;
            last_reg     <= last_pix;
            last_col_reg <= last_col;
        end
        // Shift-subtract division; sum below 1024 * area gives a 10-bit quotient
        if (cmd.div_start)
        begin
            rem_reg  <= fdm_pkg::DIV_W'(sum_reg);
            dsr_reg  <= area_top >> 1;
            quot_reg <= '0;
            step_reg <= fdm_pkg::STEP_W'(fdm_pkg::MEAN_W - 1);
            sat_reg  <= fdm_pkg::DIV_W'(sum_reg) >= area_top;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg  <= rem_reg - dsr_reg;
                quot_reg <= {quot_reg[fdm_pkg::MEAN_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[fdm_pkg::MEAN_W-2:0], 1'b0};
            end
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - fdm_pkg::STEP_W'(1);
        end
        if (cmd.load_out)
        begin
            column_reg        <= col_reg;
            row_reg_out       <= row_reg;
            bd_out_reg        <= db_reg;
            gd_out_reg        <= dg_reg;
            rd_out_reg        <= dr_reg;
            have_prev_out_reg <= prev_valid_reg;
            frame_end_reg     <= last_reg;
            if (!last_reg)
                mean_reg <= '0;
            else if (sat_reg)
                mean_reg <= fdm_pkg::MEAN_LIMIT;
            else
                mean_reg <= quot_reg;
        end
    end

    // Status to controller; frame end comes straight from the counters
    always_comb
    begin
        status.last     = last_pix;
        status.div_last = (step_reg == '0);
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign column           = column_reg;
    assign row              = row_reg_out;
    assign blue_difference  = bd_out_reg;
    assign green_difference = gd_out_reg;
    assign red_difference   = rd_out_reg;
    assign have_previous    = have_prev_out_reg;
    assign frame_end        = frame_end_reg;
    assign mean_difference  = mean_reg;

endmodule

`default_nettype wire

// ===== hdl/fdm_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdm_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output fdm_pkg::fdm_cmd_t          cmd,
    input  wire fdm_pkg::fdm_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.update = 1'b1;
                // frame end is known from the counters already
                state_next = status.last ? ST_DIV_INIT : ST_DONE;
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire
